/* sv/cfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the complex fourth root block.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int PART_BITS     = 32;
   localparam int TOL_BITS      = 16;
   localparam int RAD_BITS      = 64;
   localparam int ROOT_BITS     = RAD_BITS / 2;
   localparam int REM_BITS      = ROOT_BITS + 2;
   localparam int CELL_COUNT    = ROOT_BITS;
   localparam int ROOT_FRAC     = 24;
   localparam int SIN_BITS      = 24;
   localparam logic [SIN_BITS-1:0] HALF_ROOT2 = 24'd11863283;
   localparam logic [1:0] LAST_INDEX = 2'd3;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         final_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                  root_index;
      logic signed [PART_BITS-1:0] real_part;
      logic signed [PART_BITS-1:0] imag_part;
      logic                        last_root;
      logic                        block_end;
   } rsp_type;

   typedef struct packed {
      logic pos;
      logic zero;
      logic fin;
   } side_type;

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
      side_type             side;
   } cell_type;

endpackage

/* sv/cfr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_cell
// One square root cell: retires one root bit per request and hands on.
// ----------------------------------------------------------------------------
module cfr_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  cfr_pkg::cell_type in_data,
   output logic              out_valid,
   output cfr_pkg::cell_type out_data
);

   logic              valid_ff;
   cfr_pkg::cell_type data_ff;
   cfr_pkg::cell_type data_in;
   logic [cfr_pkg::REM_BITS+1:0] rem_wide;
   logic [cfr_pkg::REM_BITS+1:0] trial;
   logic [cfr_pkg::REM_BITS+1:0] diff;
   logic                         ge;

   always_comb begin
      rem_wide = {in_data.rem, in_data.rad[cfr_pkg::RAD_BITS-1 -: 2]};
      trial    = {2'b00, in_data.root, 2'b01};
      ge       = rem_wide >= trial;
      diff     = ge ? (rem_wide - trial) : rem_wide;
      data_in.rad  = {in_data.rad[cfr_pkg::RAD_BITS-3:0], 2'b00};
      data_in.rem  = diff[cfr_pkg::REM_BITS-1:0];
      data_in.root = {in_data.root[cfr_pkg::ROOT_BITS-2:0], ge};
      data_in.side = in_data.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* sv/cfr_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_emit
// Scale the root and send the four roots of one request in turn.
// ----------------------------------------------------------------------------
module cfr_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [cfr_pkg::ROOT_BITS-1:0]   root,
   input  cfr_pkg::side_type               side,
   output logic                            free,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cfr_pkg::rsp_type                rsp_payload
);

   logic                           valid_ff, valid_in;
   logic [1:0]                     idx_ff, idx_in;
   logic [cfr_pkg::PART_BITS-1:0]  mag_ff;
   logic                           pos_ff;
   logic                           fin_ff;
   logic [cfr_pkg::ROOT_BITS+cfr_pkg::SIN_BITS-1:0] prod;
   logic [cfr_pkg::PART_BITS-1:0]  scaled;
   logic [cfr_pkg::PART_BITS-1:0]  mag_neg;
   logic                           done;

   assign prod   = root * cfr_pkg::HALF_ROOT2;
   assign scaled = prod[cfr_pkg::ROOT_FRAC +: cfr_pkg::PART_BITS];
   assign done   = valid_ff && rsp_ready && (idx_ff == cfr_pkg::LAST_INDEX);
   assign free   = !valid_ff || done;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (valid_ff && rsp_ready) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == cfr_pkg::LAST_INDEX) begin
            valid_in = 1'b0;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= side.pos;
         fin_ff <= side.fin;
         if (side.zero) begin
            mag_ff <= '0;
         end else if (side.pos) begin
            mag_ff <= root;
         end else begin
            mag_ff <= scaled;
         end
      end
   end

   assign mag_neg = '0 - mag_ff;

   always_comb begin
      rsp_payload.root_index = idx_ff;
      rsp_payload.last_root  = idx_ff == cfr_pkg::LAST_INDEX;
      rsp_payload.block_end  = (idx_ff == cfr_pkg::LAST_INDEX) && fin_ff;
      rsp_payload.real_part  = '0;
      rsp_payload.imag_part  = '0;
      if (pos_ff) begin
         case (idx_ff)
            2'd0:    rsp_payload.real_part = mag_ff;
            2'd1:    rsp_payload.imag_part = mag_ff;
            2'd2:    rsp_payload.real_part = mag_neg;
            default: rsp_payload.imag_part = mag_neg;
         endcase
      end else begin
         case (idx_ff)
            2'd0: begin
               rsp_payload.real_part = mag_ff;
               rsp_payload.imag_part = mag_ff;
            end
            2'd1: begin
               rsp_payload.real_part = mag_neg;
               rsp_payload.imag_part = mag_ff;
            end
            2'd2: begin
               rsp_payload.real_part = mag_neg;
               rsp_payload.imag_part = mag_neg;
            end
            default: begin
               rsp_payload.real_part = mag_ff;
               rsp_payload.imag_part = mag_neg;
            end
         endcase
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* sv/complex_fourth_roots_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fourth_roots_top
// Four complex fourth roots of a signed Q16.16 value, as Q8.24 parts.
// ----------------------------------------------------------------------------
// A request passes a row of 64 square root cells, one root bit per cell:
// 32 cells for the square root of the magnitude, then 32 for the root of
// that. The row takes a request every cycle while the result stage is
// free, but the result stage sends four roots per request, one per cycle
// while the receiver is ready, so sustained intake is one request per four
// roots sent; the whole row holds while the result stage is busy.
module complex_fourth_roots_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cfr_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cfr_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [cfr_pkg::TOL_BITS-1:0]       csr_write_data
);

   localparam int STAGES = 2 * cfr_pkg::CELL_COUNT;

   logic [cfr_pkg::TOL_BITS-1:0]   tol_ff;
   logic                           advance;
   logic                           free;
   logic [cfr_pkg::VALUE_BITS-1:0] raw;
   logic                           neg;
   logic [cfr_pkg::VALUE_BITS-1:0] mag;
   logic                           chain_valid [STAGES+1];
   cfr_pkg::cell_type              chain_data  [STAGES+1];
   logic                           cell_valid  [STAGES];
   cfr_pkg::cell_type              cell_data   [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= cfr_pkg::TOL_BITS'(1);
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   assign advance   = free;
   assign req_ready = advance;

   assign raw = req_payload.value;
   assign neg = raw[cfr_pkg::VALUE_BITS-1];
   assign mag = neg ? ('0 - raw) : raw;

   assign chain_valid[0] = req_valid;
   assign chain_data[0]  = {mag, {(cfr_pkg::RAD_BITS-cfr_pkg::VALUE_BITS){1'b0}},
                            {cfr_pkg::REM_BITS{1'b0}}, {cfr_pkg::ROOT_BITS{1'b0}},
                            !neg && (raw != '0),
                            mag < cfr_pkg::VALUE_BITS'(tol_ff),
                            req_payload.final_value};

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      cfr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (cell_valid[g]),
         .out_data  (cell_data[g])
      );
      if (g == cfr_pkg::CELL_COUNT - 1) begin : g_reload
         assign chain_valid[g+1] = cell_valid[g];
         assign chain_data[g+1]  = {8'b0, cell_data[g].root, {cfr_pkg::ROOT_FRAC{1'b0}},
                                    {cfr_pkg::REM_BITS{1'b0}},
                                    {cfr_pkg::ROOT_BITS{1'b0}},
                                    cell_data[g].side};
      end else begin : g_pass
         assign chain_valid[g+1] = cell_valid[g];
         assign chain_data[g+1]  = cell_data[g];
      end
   end

   cfr_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && chain_valid[STAGES]),
      .root        (chain_data[STAGES].root),
      .side        (chain_data[STAGES].side),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sv/cfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the complex fourth root block.
// ----------------------------------------------------------------------------
module cfr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cfr_pkg::rsp_type rsp_payload
);

   a_last_mark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_root == (rsp_payload.root_index == cfr_pkg::LAST_INDEX)))
      else $error("last_root out of step with root_index");

   a_end_mark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.block_end |-> rsp_payload.last_root)
      else $error("block_end without last_root");

   a_index_step : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_root
      |=> rsp_valid && (rsp_payload.root_index == $past(rsp_payload.root_index) + 2'd1))
      else $error("roots of a request not sent in order");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind complex_fourth_roots_top cfr_checker u_cfr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for complex_fourth_roots_top.
// Signed Q16.16 requests go in on a valid/ready channel, and each one is
// expected to return four Q8.24 roots. A local predictor works out the four
// roots of every accepted request and queues them. A checker compares each
// root that leaves the block, field by field, with the oldest queued one.
// Both sides idle at random. A long receiver hold-off fills the block, and
// the zero tolerance register is swept across its extremes between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 100;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cfr_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cfr_pkg::rsp_type rsp_payload;
   logic             csr_write_enable = 1'b0;
   logic [cfr_pkg::TOL_BITS-1:0] csr_write_data = '0;

   cfr_pkg::rsp_type pending_roots[$];
   logic [cfr_pkg::TOL_BITS-1:0] tolerance = 16'd1;
   int               failures = 0;
   int               cycles = 0;
   int               requests_sent = 0;
   int               roots_checked = 0;
   int               rsp_wait = 0;
   int               rsp_hold = 0;
   bit               idle_on = 1'b1;

   complex_fourth_roots_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d roots outstanding", $time, pending_roots.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [63:0] floor_sqrt(logic [127:0] x);
      logic [63:0]  res;
      logic [127:0] t;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         t = {64'd0, res | (64'd1 << b)};
         if (t * t <= x) res = t[63:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] apply_sign(logic [63:0] mag, bit neg);
      logic [31:0] v;
      v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      return neg ? 32'd0 - v : v;
   endfunction

   task automatic predict_roots(cfr_pkg::req_type rq);
      logic [63:0] mag, s, r, a;
      logic [63:0] re_mag[4], im_mag[4];
      bit          re_neg[4], im_neg[4];
      bit          pos;
      cfr_pkg::rsp_type root;
      pos = !rq.value[cfr_pkg::VALUE_BITS-1] && rq.value != 0;
      mag = rq.value[cfr_pkg::VALUE_BITS-1] ? 64'd0 - {{32{1'b1}}, rq.value}
                                            : {32'd0, rq.value};
      for (int k = 0; k < 4; k++) begin
         re_mag[k] = '0; im_mag[k] = '0; re_neg[k] = 1'b0; im_neg[k] = 1'b0;
      end
      if (mag >= {48'd0, tolerance}) begin
         s = floor_sqrt({64'd0, mag} << 32);
         r = floor_sqrt({64'd0, s} << 24);
         if (pos) begin
            re_mag[0] = r;
            im_mag[1] = r;
            re_mag[2] = r; re_neg[2] = 1'b1;
            im_mag[3] = r; im_neg[3] = 1'b1;
         end else begin
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
            a = (r * {40'd0, cfr_pkg::HALF_ROOT2}) >> 24;
            for (int k = 0; k < 4; k++) begin
               re_mag[k] = a; im_mag[k] = a;
            end
            re_neg[1] = 1'b1;
            re_neg[2] = 1'b1; im_neg[2] = 1'b1;
            im_neg[3] = 1'b1;
         end
      end
      for (int k = 0; k < 4; k++) begin
         root.root_index = k[1:0];
         root.real_part  = apply_sign(re_mag[k], re_neg[k]);
         root.imag_part  = apply_sign(im_mag[k], im_neg[k]);
         root.last_root  = (k[1:0] == cfr_pkg::LAST_INDEX);
         root.block_end  = (k[1:0] == cfr_pkg::LAST_INDEX) && rq.final_value;
         pending_roots.push_back(root);
      end
   endtask

   // receiver: hold off, then take one root after a random wait
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cfr_pkg::rsp_type exp_root;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_wait = idle_on ? $urandom_range(0, 13) : 0;
         if (pending_roots.size() == 0) begin
            $display("%0t unexpected root: expected none actual %h", $time, rsp_payload);
            failures++;
         end else begin
            exp_root = pending_roots.pop_front();
            roots_checked++;
            if (rsp_payload.root_index !== exp_root.root_index) begin
               $display("%0t root_index: expected %0d actual %0d", $time,
                        exp_root.root_index, rsp_payload.root_index);
               failures++;
            end
            if (rsp_payload.real_part !== exp_root.real_part) begin
               $display("%0t real_part: expected %h actual %h", $time,
                        exp_root.real_part, rsp_payload.real_part);
               failures++;
            end
            if (rsp_payload.imag_part !== exp_root.imag_part) begin
               $display("%0t imag_part: expected %h actual %h", $time,
                        exp_root.imag_part, rsp_payload.imag_part);
               failures++;
            end
            if (rsp_payload.last_root !== exp_root.last_root) begin
               $display("%0t last_root: expected %b actual %b", $time,
                        exp_root.last_root, rsp_payload.last_root);
               failures++;
            end
            if (rsp_payload.block_end !== exp_root.block_end) begin
               $display("%0t block_end: expected %b actual %b", $time,
                        exp_root.block_end, rsp_payload.block_end);
               failures++;
            end
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_request(logic [31:0] value, bit fin);
      int gap;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload.value       <= value;
      req_payload.final_value <= fin;
      req_valid               <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_roots(req_payload);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (pending_roots.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [cfr_pkg::TOL_BITS-1:0] tol);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= tol;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tolerance = tol;
   endtask

   function automatic logic [31:0] random_value();
      int pick;
      logic [31:0] mag;
      pick = $urandom_range(0, 9);
      if (pick < 6) return $urandom;
      mag = (pick < 8) ? {16'd0, tolerance} + $urandom_range(0, 4) - 2
                       : $urandom_range(0, 1 << 20);
      return $urandom_range(0, 1) ? 32'd0 - mag : mag;
   endfunction

   task automatic test_directed;
      logic [31:0] edge_vals[12];
      edge_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0001_0000, 32'hFFFF_0000, 32'h0010_0000, 32'hFFF0_0000,
                    32'h0000_0002, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (edge_vals[i]) send_request(edge_vals[i], i[0]);
      write_tolerance(16'd0);
      send_request(32'd0, 1'b1);
      send_request(32'd1, 1'b0);
      write_tolerance(16'hFFFF);
      send_request(32'h0000_FFFE, 1'b0);
      send_request(32'hFFFF_0002, 1'b1);
      send_request(32'h0000_FFFF, 1'b0);
      send_request(32'hFFFF_0001, 1'b1);
   endtask

   task automatic test_random;
      logic [cfr_pkg::TOL_BITS-1:0] settings[4];
      settings = '{16'd1, 16'd0, 16'hFFFF, 16'd0};
      settings[3] = 16'($urandom);
      foreach (settings[p]) begin
         write_tolerance(settings[p]);
         idle_on = (p != 2);
         repeat (100) send_request(random_value(), 1'($urandom_range(0, 1)));
         idle_on = 1'b1;
      end
   endtask

   task automatic test_backpressure;
      write_tolerance(16'd1);
      rsp_hold = 400;
      repeat (30) send_request($urandom, 1'($urandom_range(0, 1)));
      drain();
      repeat (10) send_request(random_value(), 1'b1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random();
      test_backpressure();
      drain();
      $display("%0d requests sent, %0d roots checked over tolerance sweeps and stalls",
               requests_sent, roots_checked);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", failures);
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
sv/cfr_pkg.sv
sv/cfr_cell.sv
sv/cfr_emit.sv
sv/complex_fourth_roots_top.sv
sv/cfr_checker.sv
tb/tb.sv
